>>> rtl/core/four_queue_fifo_with_selection_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the four-queue FIFO selector
// Implication checks on a clock with synchronous reset; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef FOUR_QUEUE_FIFO_WITH_SELECTION_MACROS_SVH
`define FOUR_QUEUE_FIFO_WITH_SELECTION_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define FQFS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define FQFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define FQFS_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define FQFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

>>> rtl/core/fqfs_pkg.sv
// ---------------------------------------------------------------------------
// Four-queue FIFO selector package
// Shared widths, operation and status codes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fqfs_pkg;

   localparam int NUM_QUEUES = 4;
   localparam int QIDX_W     = 2;
   localparam int ID_W       = 16;
   localparam int TOTAL_W    = 7;
   localparam int SERVE_W    = 16;

   localparam logic [SERVE_W-1:0] SERVE_MAX = {SERVE_W{1'b1}};

   // request tuser: op, queue_index
   localparam int REQ_USER_W = 1 + QIDX_W;
   // result tdata: vehicle_out, total_waiting, four picks, one pad bit
   localparam int RSP_DATA_W = 32;

   typedef enum logic {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

endpackage

`default_nettype wire

>>> rtl/core/four_queue_fifo_with_selection.sv
// ---------------------------------------------------------------------------
// Four-queue FIFO selector
// Four identifier FIFOs with service counters and four queue picks per request.
// ---------------------------------------------------------------------------
// Each request either pushes a 16-bit identifier into one of four FIFOs or
// pops that FIFO's head, and returns exactly one result: the popped
// identifier (zero otherwise), a status (ok, full and dropped, empty), the
// total number of waiting entries and four picks taken over the state after
// the request (smallest non-empty queue, largest queue, least-served and
// most-served queue, ties to the lowest index). A request is accepted every
// cycle as long as the result register is empty or is being drained in the
// same cycle; its result appears in the cycle after acceptance. Occupancy,
// head pointers and service counters live in flip-flops; the identifiers sit
// in one memory of 4 * 2^ceil(log2(QUEUE_DEPTH)) words with one write port
// and a registered read of the addressed queue's head, which feeds the result
// directly. The store needs no clearing after reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "four_queue_fifo_with_selection_macros.svh"

module four_queue_fifo_with_selection #(
   parameter int QUEUE_DEPTH = 16            // entries per queue, 2..31
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [fqfs_pkg::ID_W-1:0]         req_tdata,   // [15:0] vehicle_id
   input  wire logic [fqfs_pkg::REQ_USER_W-1:0]   req_tuser,   // [0] op, [2:1] queue_index
   // result channel
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [15:0] vehicle_out, [22:16] total_waiting, [24:23] fewest_queue,
   // [26:25] most_queue, [28:27] least_served_queue,
   // [30:29] most_served_queue, [31] zero
   output logic [fqfs_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic [1:0]                             rsp_tuser    // [1:0] status
);

   import fqfs_pkg::*;

   // pointer, occupancy and store address widths
   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W = QIDX_W + PTR_W;
   localparam int MEM_D  = 1 << ADDR_W;
   localparam int SUM_W  = CNT_W + 2;

   localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W + 1)'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);

   // state
   logic [CNT_W-1:0]   cnt_ff  [NUM_QUEUES];
   logic [CNT_W-1:0]   cnt_in  [NUM_QUEUES];
   logic [PTR_W-1:0]   head_ff [NUM_QUEUES];
   logic [PTR_W-1:0]   head_in [NUM_QUEUES];
   logic [SERVE_W-1:0] srv_ff  [NUM_QUEUES];
   logic [SERVE_W-1:0] srv_in  [NUM_QUEUES];
   logic [ID_W-1:0]    queue_store_ff [MEM_D];

   // result register
   logic               rsp_valid_ff;
   logic               deq_ok_ff, deq_ok_in;
   logic [ID_W-1:0]    head_data_ff;
   status_type         status_ff, status_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [QIDX_W-1:0]  fewest_ff, fewest_in;
   logic [QIDX_W-1:0]  most_ff, most_in;
   logic [QIDX_W-1:0]  lserv_ff, lserv_in;
   logic [QIDX_W-1:0]  mserv_ff, mserv_in;

   // request decode
   logic               accept;
   op_type             op;
   logic [QIDX_W-1:0]  qsel;
   logic [CNT_W-1:0]   cnt_cur;
   logic [PTR_W-1:0]   head_cur;
   logic [PTR_W:0]     tail_sum;
   logic [PTR_W-1:0]   tail_pos;
   logic               q_full, q_empty;
   logic               wr_en;

   // the result register frees up whenever the downstream takes it
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign op         = op_type'(req_tuser[0]);
   assign qsel       = req_tuser[2:1];

   assign cnt_cur  = cnt_ff[qsel];
   assign head_cur = head_ff[qsel];
   assign q_full   = (cnt_cur == CNT_FULL);
   assign q_empty  = (cnt_cur == '0);

   // write slot: head + occupancy, wrapped once (occupancy < depth here)
   assign tail_sum = (PTR_W + 1)'(head_cur) + (PTR_W + 1)'(cnt_cur);
   assign tail_pos = (tail_sum >= DEPTH_EXT) ? PTR_W'(tail_sum - DEPTH_EXT)
                                             : PTR_W'(tail_sum);
   assign wr_en    = accept && (op == OP_ENQUEUE) && !q_full;

   // next state and status
   always_comb begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
         cnt_in[i]  = cnt_ff[i];
         head_in[i] = head_ff[i];
         srv_in[i]  = srv_ff[i];
      end
      status_in = STATUS_OK;
      deq_ok_in = 1'b0;
      unique case (op)
         OP_ENQUEUE: begin
            if (q_full) begin
               status_in = STATUS_FULL;
            end else begin
               cnt_in[qsel] = cnt_cur + 1'b1;
            end
         end
         OP_DEQUEUE: begin
            if (q_empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               deq_ok_in     = 1'b1;
               cnt_in[qsel]  = cnt_cur - 1'b1;
               head_in[qsel] = (head_cur == PTR_LAST) ? '0 : head_cur + 1'b1;
               if (srv_ff[qsel] != SERVE_MAX) begin
                  srv_in[qsel] = srv_ff[qsel] + 1'b1;
               end
            end
         end
      endcase
   end

   // picks over the post-request state, lowest index wins ties
   always_comb begin
      logic [SUM_W-1:0] sum;
      logic             have_nonempty;
      sum           = '0;
      have_nonempty = 1'b0;
      fewest_in     = '0;
      most_in       = '0;
      lserv_in      = '0;
      mserv_in      = '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
         sum = sum + SUM_W'(cnt_in[i]);
         if (cnt_in[i] != '0 && (!have_nonempty || cnt_in[i] < cnt_in[fewest_in])) begin
            fewest_in     = QIDX_W'(i);
            have_nonempty = 1'b1;
         end
         if (cnt_in[i] > cnt_in[most_in]) begin
            most_in = QIDX_W'(i);
         end
         if (srv_in[i] < srv_in[lserv_in]) begin
            lserv_in = QIDX_W'(i);
         end
         if (srv_in[i] > srv_in[mserv_in]) begin
            mserv_in = QIDX_W'(i);
         end
      end
      total_in = TOTAL_W'(sum);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            cnt_ff[i]  <= '0;
            head_ff[i] <= '0;
            srv_ff[i]  <= '0;
         end
      end else begin
         if (accept) begin
            rsp_valid_ff <= 1'b1;
            for (int i = 0; i < NUM_QUEUES; i++) begin
               cnt_ff[i]  <= cnt_in[i];
               head_ff[i] <= head_in[i];
               srv_ff[i]  <= srv_in[i];
            end
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // identifier store: one write, registered head read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         queue_store_ff[{qsel, tail_pos}] <= req_tdata;
      end
      if (accept) begin
         head_data_ff <= queue_store_ff[{qsel, head_cur}];
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         deq_ok_ff <= deq_ok_in;
         status_ff <= status_in;
         total_ff  <= total_in;
         fewest_ff <= fewest_in;
         most_ff   <= most_in;
         lserv_ff  <= lserv_in;
         mserv_ff  <= mserv_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {1'b0, mserv_ff, lserv_ff, most_ff, fewest_ff, total_ff,
                        (deq_ok_ff ? head_data_ff : {ID_W{1'b0}})};

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   `FQFS_ASSERT_IMPL(a_failed_zero_id, clock, reset,
      rsp_tvalid && rsp_tuser != STATUS_OK, rsp_tdata[ID_W-1:0] == '0,
      "failed request returned a non-zero identifier")
   `FQFS_ASSERT_IMPL(a_stall_cause, clock, reset,
      !req_tready, rsp_tvalid && !rsp_tready,
      "request side stalled without a blocked result")
   `FQFS_ASSERT_NEXT(a_result_follows, clock, reset,
      req_tvalid && req_tready, rsp_tvalid,
      "accepted request produced no result")

endmodule

`default_nettype wire

>>> tb/sv/tb_four_queue_fifo_with_selection.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the four-queue FIFO selector
// A short directed script (empty pop, extreme identifiers, fill to full, wrap)
// is followed by random push/pop traffic under several idling patterns.
// Every result is checked field by field, typed script rows against their hand-written
// result, all others against a predictor that tracks the four queues and their service counters.
// ---------------------------------------------------------------------------

module tb_four_queue_fifo_with_selection;

   import fqfs_pkg::*;

   localparam int DEPTH = 16;

   // one result as the block should report it
   typedef struct packed {
      logic [ID_W-1:0]    vehicle;
      status_type         status;
      logic [TOTAL_W-1:0] total;
      logic [1:0]         fewest;
      logic [1:0]         most;
      logic [1:0]         least_served;
      logic [1:0]         most_served;
   } outcome_type;

   // one line of the directed script; typed rows carry a hand-written result
   typedef struct {
      op_type          op;
      logic [1:0]      lane;
      logic [ID_W-1:0] ident;
      logic            typed;
      outcome_type     outcome;
   } script_row_type;

   logic                    clock;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [ID_W-1:0]         req_tdata  = '0;
   logic [REQ_USER_W-1:0]   req_tuser  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic [1:0]              rsp_tuser;

   // predictor state: queued identifiers and service counters per queue
   logic [ID_W-1:0]    lane_ids [NUM_QUEUES][$];
   logic [SERVE_W-1:0] served   [NUM_QUEUES];

   outcome_type expected_results [$];

   // idling controls, flipped between phases
   logic sender_idle    = 1'b0;
   logic receiver_stall = 1'b0;
   int   idle_pct       = 56;

   int mismatches      = 0;
   int results_checked = 0;
   int pushes          = 0;
   int pops            = 0;
   int full_drops      = 0;
   int empty_pops      = 0;

   four_queue_fifo_with_selection #(
      .QUEUE_DEPTH (DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop if the run never finishes.
   initial begin
      #2_000_000;
      $display("four_queue_fifo_with_selection verification failed");
      $finish;
   end

   // Apply one accepted request to the predictor and return its result.
   // Picks are taken over the state after the request, ties to lowest index.
   function automatic outcome_type apply_request(input op_type op, input logic [1:0] lane,
                                                 input logic [ID_W-1:0] ident);
      outcome_type res;
      int          occ;
      logic        seen;
      res  = '0;
      seen = 1'b0;
      res.status = STATUS_OK;
      if (op == OP_ENQUEUE) begin
         pushes++;
         if (lane_ids[lane].size() >= DEPTH) begin
            res.status = STATUS_FULL;
            full_drops++;
         end else begin
            lane_ids[lane].push_back(ident);
         end
      end else begin
         pops++;
         if (lane_ids[lane].size() == 0) begin
            res.status = STATUS_EMPTY;
            empty_pops++;
         end else begin
            res.vehicle = lane_ids[lane].pop_front();
            if (served[lane] != SERVE_MAX) served[lane]++;
         end
      end
      for (int i = 0; i < NUM_QUEUES; i++) begin
         occ = lane_ids[i].size();
         res.total = res.total + TOTAL_W'(occ);
         if (occ > 0 && (!seen || occ < lane_ids[res.fewest].size())) begin
            res.fewest = 2'(i);
            seen       = 1'b1;
         end
         if (occ > lane_ids[res.most].size()) res.most = 2'(i);
         if (served[i] < served[res.least_served]) res.least_served = 2'(i);
         if (served[i] > served[res.most_served]) res.most_served = 2'(i);
      end
      return res;
   endfunction

   // Present one request, hold it until accepted, then log its expected result.
   // The valid is only dropped when a gap follows, so it never toggles twice
   // in one time step.
   task automatic issue_request(input op_type op, input logic [1:0] lane,
                                input logic [ID_W-1:0] ident, input logic typed,
                                input outcome_type typed_outcome);
      outcome_type predicted;
      while (sender_idle && ($urandom_range(99) < idle_pct)) begin
         req_tvalid <= 1'b0;
         req_tdata  <= ID_W'($urandom);
         req_tuser  <= REQ_USER_W'($urandom);
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ident;
      req_tuser  <= {lane, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = apply_request(op, lane, ident);
      expected_results.push_back(typed ? typed_outcome : predicted);
   endtask

   function automatic void compare_field(input string name, input logic [15:0] want,
                                         input logic [15:0] got);
      if (want !== got) begin
         $error("%s expected %0h got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // Result side: random back-pressure and the check against the oldest
   // expectation. Values are read before the edge's updates land.
   always @(posedge clock) begin : result_check
      outcome_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(receiver_stall && ($urandom_range(99) < idle_pct));
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("result %0h/%0h arrived with no request outstanding",
                   rsp_tdata, rsp_tuser);
            mismatches++;
         end else begin
            want = expected_results.pop_front();
            results_checked++;
            compare_field("vehicle_out",        want.vehicle,      rsp_tdata[15:0]);
            compare_field("status",             want.status,       rsp_tuser);
            compare_field("total_waiting",      want.total,        rsp_tdata[22:16]);
            compare_field("fewest_queue",       want.fewest,       rsp_tdata[24:23]);
            compare_field("most_queue",         want.most,         rsp_tdata[26:25]);
            compare_field("least_served_queue", want.least_served, rsp_tdata[28:27]);
            compare_field("most_served_queue",  want.most_served,  rsp_tdata[30:29]);
            compare_field("pad bit",            1'b0,              rsp_tdata[31]);
         end
      end
   end

   initial begin : stimulus
      script_row_type script [$];
      op_type         op;
      logic [1:0]     lane;
      int             push_bias;
      int             run_left;

      for (int i = 0; i < NUM_QUEUES; i++) served[i] = '0;

      // ---- directed script ----
      // pop from an empty queue straight after reset: everything zero
      script.push_back('{OP_DEQUEUE, 2'd0, 16'h1357, 1'b1,
         '{vehicle: 16'h0, status: STATUS_EMPTY, total: 7'd0, fewest: 2'd0,
           most: 2'd0, least_served: 2'd0, most_served: 2'd0}});
      // largest identifier into the last queue
      script.push_back('{OP_ENQUEUE, 2'd3, 16'hFFFF, 1'b1,
         '{vehicle: 16'h0, status: STATUS_OK, total: 7'd1, fewest: 2'd3,
           most: 2'd3, least_served: 2'd0, most_served: 2'd0}});
      // smallest identifier; queues 2 and 3 tie, lower index wins
      script.push_back('{OP_ENQUEUE, 2'd2, 16'h0000, 1'b1,
         '{vehicle: 16'h0, status: STATUS_OK, total: 7'd2, fewest: 2'd2,
           most: 2'd2, least_served: 2'd0, most_served: 2'd0}});
      script.push_back('{OP_DEQUEUE, 2'd3, 16'h0000, 1'b1,
         '{vehicle: 16'hFFFF, status: STATUS_OK, total: 7'd1, fewest: 2'd2,
           most: 2'd2, least_served: 2'd0, most_served: 2'd3}});
      // back to all empty; service counts tie on 2 and 3
      script.push_back('{OP_DEQUEUE, 2'd2, 16'hFFFF, 1'b1,
         '{vehicle: 16'h0000, status: STATUS_OK, total: 7'd0, fewest: 2'd0,
           most: 2'd0, least_served: 2'd0, most_served: 2'd2}});
      // fill queue 1 with alternating bit patterns
      for (int k = 0; k < DEPTH; k++)
         script.push_back('{OP_ENQUEUE, 2'd1, (k[0] ? 16'hAAAA : 16'h5555) ^ k[15:0],
                            1'b0, '0});
      // one more push: dropped as full
      script.push_back('{OP_ENQUEUE, 2'd1, 16'h1234, 1'b1,
         '{vehicle: 16'h0, status: STATUS_FULL, total: 7'd16, fewest: 2'd1,
           most: 2'd1, least_served: 2'd0, most_served: 2'd2}});
      // pop the oldest, then push into the freed slot across the wrap
      script.push_back('{OP_DEQUEUE, 2'd1, 16'h0000, 1'b0, '0});
      script.push_back('{OP_ENQUEUE, 2'd1, 16'hBEEF, 1'b0, '0});

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (script[r])
         issue_request(script[r].op, script[r].lane, script[r].ident,
                       script[r].typed, script[r].outcome);

      // ---- random traffic ----
      // Push-heavy and pop-heavy stretches alternate so queues run to full and
      // to empty; a slice of requests is plain noise.
      push_bias = 75;
      run_left  = 0;
      for (int n = 0; n < 1250; n++) begin
         case (n / 250)
            0: begin sender_idle = 1'b0; receiver_stall = 1'b0; idle_pct = 56; end
            1: begin sender_idle = 1'b1; receiver_stall = 1'b0; idle_pct = 56; end
            2: begin sender_idle = 1'b0; receiver_stall = 1'b1; idle_pct = 56; end
            3: begin sender_idle = 1'b1; receiver_stall = 1'b1; idle_pct = 28; end
            default: begin sender_idle = 1'b0; receiver_stall = 1'b0; idle_pct = 56; end
         endcase
         if (run_left == 0) begin
            push_bias = (push_bias > 50) ? 25 : 75;
            run_left  = $urandom_range(80, 20);
         end
         run_left--;
         if ($urandom_range(9) == 0)
            op = $urandom_range(1) ? OP_DEQUEUE : OP_ENQUEUE;
         else
            op = ($urandom_range(99) < push_bias) ? OP_ENQUEUE : OP_DEQUEUE;
         lane = 2'($urandom_range(3));
         issue_request(op, lane, ID_W'($urandom), 1'b0, '0);
      end

      req_tvalid <= 1'b0;

      // drain, then watch a little longer for stray results
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Checked %0d results: %0d pushes (%0d dropped as full), %0d pops (%0d empty)",
               results_checked, pushes, full_drops, pops, empty_pops);
      $display("Idling patterns: none, sender, receiver, both; queue 0 service count %0d",
               served[0]);
      if (mismatches == 0) begin
         $display("four_queue_fifo_with_selection verification clean");
      end else begin
         $display("four_queue_fifo_with_selection verification failed");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/fqfs_pkg.sv
rtl/core/four_queue_fifo_with_selection.sv
tb/sv/tb_four_queue_fifo_with_selection.sv
